>>> rtl/core/cca_pkg.sv
package cca_pkg;

  // Field widths of the request and reply words
  localparam int OP_W     = 1;
  localparam int TAG_W    = 16;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;
  localparam int START_W  = 10;
  localparam int FREED_W  = 11;
  localparam int POLICY_W = 2;

  // Request kinds
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

  // Reply status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd2;

  // Placement policies; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,   // clearing pass over the cell map after reset
    S_IDLE,   // waiting for a request
    S_SCAN,   // walking the map for free runs
    S_FILL,   // stamping the chosen run with the tag
    S_FREE,   // read-modify-write pass releasing a tag
    S_REPLY   // handing the reply word to the output register
  } cca_state_t;

endpackage

>>> rtl/core/contiguous_cell_allocator.sv
// Channel   Signals                                      Direction
// -------   -------------------------------------------  ---------
// request   in_valid, in_stall, operation, owner_tag,    in
//           block_size
// reply     out_valid, out_stall, status, start_cell,    out
//           cells_freed
// config    cfg_valid, cfg_ready, fit_policy             in
//
// Allocate: accept, scan of the map for free runs (first fit stops early), fill of
// block_size cells, reply. Clear: accept, read-modify-write pass over every cell, reply.
// The cell-map RAM takes one read and one write per cycle.
// After reset a clearing pass zeroes the map; input is stalled.
// A stalled reply holds in the output register while the next request is accepted.
module contiguous_cell_allocator #(
  parameter int CELL_COUNT = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cca_pkg::OP_W-1:0]       operation,
  input  logic [cca_pkg::TAG_W-1:0]      owner_tag,
  input  logic [cca_pkg::SIZE_W-1:0]     block_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cca_pkg::STATUS_W-1:0]   status,
  output logic [cca_pkg::START_W-1:0]    start_cell,
  output logic [cca_pkg::FREED_W-1:0]    cells_freed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cca_pkg::POLICY_W-1:0]   fit_policy
);

  import cca_pkg::*;

  localparam int CW    = $clog2(CELL_COUNT);
  localparam int CNT_W = CW + 1;
  localparam int SZW   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int TW    = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;
  localparam int SOW   = (CW > START_W) ? CW : START_W;
  localparam int FOW   = (CNT_W > FREED_W) ? CNT_W : FREED_W;

  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] END_CELL  = CNT_W'(CELL_COUNT);

  cca_state_t state, state_next;

  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CW-1:0]       run_start, run_start_next;
  logic [CNT_W-1:0]    run_len, run_len_next;
  logic                found, found_next;
  logic [CW-1:0]       best_start, best_start_next;
  logic [CNT_W-1:0]    best_len, best_len_next;
  logic [CW-1:0]       wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]    freed, freed_next;
  logic [TAG_BITS-1:0] req_tag, req_tag_next;
  logic [SIZE_W-1:0]   req_size, req_size_next;
  logic [POLICY_W-1:0] policy;
  logic [STATUS_W-1:0] res_status, res_status_next;

  logic                out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [START_W-1:0]  start_cell_next;
  logic [FREED_W-1:0]  cells_freed_next;

  // Cell map access
  logic                mem_we;
  logic [CW-1:0]       mem_waddr;
  logic [TAG_BITS-1:0] mem_wdata;
  logic [CW-1:0]       mem_raddr;
  logic [TAG_BITS-1:0] mem_rdata;

  // Scratch
  logic [CNT_W-1:0]    cnt_inc;
  logic [TW-1:0]       tag_wide;
  logic [TAG_BITS-1:0] tag_in;
  logic                cell_free;
  logic                run_fits;
  logic                go_fill;
  logic [SOW-1:0]      start_wide;
  logic [FOW-1:0]      freed_wide;

  cca_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(CELL_COUNT)
  ) u_cell_map (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Next state, datapath and RAM control
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    run_start_next   = run_start;
    run_len_next     = run_len;
    found_next       = found;
    best_start_next  = best_start;
    best_len_next    = best_len;
    wr_ptr_next      = wr_ptr;
    freed_next       = freed;
    req_tag_next     = req_tag;
    req_size_next    = req_size;
    res_status_next  = res_status;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    start_cell_next  = start_cell;
    cells_freed_next = cells_freed;

    cnt_inc   = cnt + CNT_W'(1);
    tag_wide  = TW'(owner_tag);
    tag_in    = tag_wide[TAG_BITS-1:0];
    cell_free = (cnt != END_CELL) && (mem_rdata == '0);
    run_fits  = (run_len != '0) && (SZW'(run_len) >= SZW'(req_size));
    go_fill   = 1'b0;
    start_wide = SOW'(best_start);
    freed_wide = FOW'(freed);

    mem_we    = 1'b0;
    mem_waddr = cnt[CW-1:0];
    mem_wdata = '0;
    mem_raddr = cnt_inc[CW-1:0];

    case (state)
      S_INIT: begin
        mem_we   = 1'b1;
        cnt_next = cnt_inc;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        // Keep cell 0 on the read port so a pass starts with its data
        mem_raddr = '0;
        if (in_valid) begin
          req_tag_next    = tag_in;
          req_size_next   = block_size;
          cnt_next        = '0;
          run_start_next  = '0;
          run_len_next    = '0;
          found_next      = 1'b0;
          best_start_next = '0;
          best_len_next   = '0;
          freed_next      = '0;
          res_status_next = STAT_DONE;
          if (tag_in == '0) begin
            res_status_next = STAT_BAD;
            state_next      = S_REPLY;
          end else if (operation == OP_CLEAR) begin
            state_next = S_FREE;
          end else if (block_size == '0) begin
            res_status_next = STAT_BAD;
            state_next      = S_REPLY;
          end else if (SZW'(block_size) > SZW'(CELL_COUNT)) begin
            res_status_next = STAT_NOFIT;
            state_next      = S_REPLY;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Cell cnt is on the read port; cnt == CELL_COUNT closes the last run
        cnt_next = cnt_inc;
        if (cell_free) begin
          if (run_len == '0) begin
            run_start_next = cnt[CW-1:0];
          end
          run_len_next = run_len + CNT_W'(1);
        end else begin
          run_len_next = '0;
          if (run_fits) begin
            if (!found) begin
              found_next      = 1'b1;
              best_start_next = run_start;
              best_len_next   = run_len;
              if (policy != POL_BEST && policy != POL_WORST) begin
                go_fill = 1'b1;
              end
            end else if (policy == POL_BEST && run_len < best_len) begin
              best_start_next = run_start;
              best_len_next   = run_len;
            end else if (policy == POL_WORST && run_len > best_len) begin
              best_start_next = run_start;
              best_len_next   = run_len;
            end
          end
        end
        if (go_fill || (cnt == END_CELL && found_next)) begin
          wr_ptr_next = best_start_next;
          cnt_next    = '0;
          state_next  = S_FILL;
        end else if (cnt == END_CELL) begin
          res_status_next = STAT_NOFIT;
          state_next      = S_REPLY;
        end
      end

      S_FILL: begin
        mem_we      = 1'b1;
        mem_waddr   = wr_ptr;
        mem_wdata   = req_tag;
        wr_ptr_next = wr_ptr + CW'(1);
        cnt_next    = cnt_inc;
        if (SZW'(cnt_inc) == SZW'(req_size)) begin
          state_next = S_REPLY;
        end
      end

      S_FREE: begin
        // Read cell cnt+1 while releasing cell cnt
        cnt_next = cnt_inc;
        if (mem_rdata == req_tag) begin
          mem_we     = 1'b1;
          freed_next = freed + CNT_W'(1);
        end
        if (cnt == LAST_CELL) begin
          state_next = S_REPLY;
        end
      end

      S_REPLY: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          start_cell_next  = (res_status == STAT_DONE) ? start_wide[START_W-1:0] : '0;
          cells_freed_next = freed_wide[FREED_W-1:0];
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_INIT;
        cnt_next   = '0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      policy    <= POL_FIRST;
    end else begin
      cnt       <= cnt_next;
      found     <= found_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        policy <= fit_policy;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_start   <= run_start_next;
    run_len     <= run_len_next;
    best_start  <= best_start_next;
    best_len    <= best_len_next;
    wr_ptr      <= wr_ptr_next;
    freed       <= freed_next;
    req_tag     <= req_tag_next;
    req_size    <= req_size_next;
    res_status  <= res_status_next;
    status      <= status_next;
    start_cell  <= start_cell_next;
    cells_freed <= cells_freed_next;
  end

endmodule

>>> rtl/core/cca_ram.sv
module cca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> bench/cca_checker.sv
`timescale 1ns / 100ps

module cca_checker
  import cca_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [TAG_W-1:0]    owner_tag,
  input  logic [SIZE_W-1:0]   block_size,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] status,
  input  logic [START_W-1:0]  start_cell,
  input  logic [FREED_W-1:0]  cells_freed,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [POLICY_W-1:0] fit_policy,
  output int                  fail_count,
  output int                  pending
);

  localparam int CELLS = 1024;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_cell;
    logic [FREED_W-1:0]  cells_freed;
  } reply_word_t;

  // Shadow copy of the cell map and placement policy
  logic [TAG_W-1:0]    owner_map [CELLS];
  logic [POLICY_W-1:0] policy;
  reply_word_t         replies_due [$];

  task automatic report(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one request to the shadow map and return the reply it earns
  function automatic reply_word_t serve_request(logic [OP_W-1:0] op,
                                                logic [TAG_W-1:0] tag,
                                                logic [SIZE_W-1:0] size);
    reply_word_t r;
    int run_start, run_len, pick, pick_len, freed;
    bit found, is_free;
    r = '0;
    r.status = STAT_DONE;
    run_start = 0;
    run_len = 0;
    pick = 0;
    pick_len = 0;
    freed = 0;
    found = 1'b0;
    if (tag == '0) begin
      r.status = STAT_BAD;
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++) begin
        if (owner_map[i] == tag) begin
          owner_map[i] = '0;
          freed++;
        end
      end
      r.cells_freed = freed[FREED_W-1:0];
    end else if (size == '0) begin
      r.status = STAT_BAD;
    end else begin
      // walk free runs; one step past the end closes the trailing run
      if (size <= CELLS) begin
        for (int i = 0; i <= CELLS; i++) begin
          if (i < CELLS) is_free = (owner_map[i] == '0);
          else is_free = 1'b0;
          if (is_free) begin
            if (run_len == 0) run_start = i;
            run_len++;
          end else begin
            if (run_len >= size && run_len > 0) begin
              if (!found) begin
                found = 1'b1;
                pick = run_start;
                pick_len = run_len;
                if (policy != POL_BEST && policy != POL_WORST) break;
              end else if (policy == POL_BEST && run_len < pick_len) begin
                pick = run_start;
                pick_len = run_len;
              end else if (policy == POL_WORST && run_len > pick_len) begin
                pick = run_start;
                pick_len = run_len;
              end
            end
            run_len = 0;
          end
        end
      end
      if (!found) begin
        r.status = STAT_NOFIT;
      end else begin
        for (int k = 0; k < size; k++) owner_map[pick + k] = tag;
        r.start_cell = pick[START_W-1:0];
      end
    end
    return r;
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    reply_word_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) owner_map[i] = '0;
      policy = POL_FIRST;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) policy = fit_policy;
      // reply word against oldest expectation
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report($sformatf("reply with none due (status %0d start %0d freed %0d)",
                           status, start_cell, cells_freed));
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
          if (start_cell !== want.start_cell)
            report($sformatf("start_cell %0d, expected %0d", start_cell, want.start_cell));
          if (cells_freed !== want.cells_freed)
            report($sformatf("cells_freed %0d, expected %0d", cells_freed,
                             want.cells_freed));
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(serve_request(operation, owner_tag, block_size));
    end
    pending <= replies_due.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import cca_pkg::*;

  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;  // unused code, acts as first fit
  localparam int HOLD_CYCLES = 6000;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAG_POOL    = 12;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 38;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     operation;
  logic [TAG_W-1:0]    owner_tag;
  logic [SIZE_W-1:0]   block_size;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_cell;
  logic [FREED_W-1:0]  cells_freed;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [POLICY_W-1:0] fit_policy;

  int fail_count;
  int pending;
  int cycles = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  logic [TAG_W-1:0]    tag_pool [TAG_POOL];
  logic [POLICY_W-1:0] pol_order [PHASES];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  contiguous_cell_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .owner_tag(owner_tag), .block_size(block_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .start_cell(start_cell), .cells_freed(cells_freed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_policy(fit_policy)
  );

  cca_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .owner_tag(owner_tag), .block_size(block_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .start_cell(start_cell), .cells_freed(cells_freed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_policy(fit_policy),
    .fail_count(fail_count), .pending(pending)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reply side: random stall bursts, and one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request word and hold it until taken
  task automatic put_request(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                             logic [SIZE_W-1:0] size);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    owner_tag  <= tag;
    block_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait for every reply due
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_policy(logic [POLICY_W-1:0] p);
    cfg_valid  <= 1'b1;
    fit_policy <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly live-tag allocates and clears, with some malformed words
  task automatic random_request();
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    int roll;
    roll = $urandom_range(0, 99);
    op   = (roll < 35) ? OP_CLEAR : OP_ALLOC;
    tag  = tag_pool[$urandom_range(0, TAG_POOL-1)];
    roll = $urandom_range(0, 99);
    if (roll < 82) size = SIZE_W'($urandom_range(1, 48));
    else if (roll < 93) size = SIZE_W'($urandom_range(49, 400));
    else if (roll < 97) size = SIZE_W'($urandom_range(401, 1024));
    else size = SIZE_W'($urandom_range(1025, 2047));
    roll = $urandom_range(0, 99);
    if (roll < 3) tag = '0;
    else if (roll < 6) size = '0;
    else if (roll < 9) tag = TAG_W'($urandom);
    put_request(op, tag, size);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_ALLOC;
    owner_tag  = '0;
    block_size = '0;
    cfg_valid  = 1'b0;
    fit_policy = POL_FIRST;
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom_range(1, 65535));
    pol_order = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST, POL_WORST, POL_BEST,
                  POL_FIRST};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // malformed words, full map, then a fragmented map under each policy
    set_policy(POL_FIRST);
    put_request(OP_ALLOC, '0, 11'd5);           // zero tag
    put_request(OP_ALLOC, 16'd1, '0);           // zero size
    put_request(OP_CLEAR, '0, '0);              // zero tag on clear
    put_request(OP_CLEAR, 16'd7, 11'd2047);     // tag not present
    put_request(OP_ALLOC, 16'd9, 11'd2047);     // oversize
    put_request(OP_ALLOC, 16'd9, 11'd1025);     // one past the map
    put_request(OP_ALLOC, 16'hFFFF, 11'd1024);  // whole map
    put_request(OP_ALLOC, 16'd2, 11'd1);        // map full
    put_request(OP_CLEAR, 16'hFFFF, '0);        // frees 1024
    put_request(OP_ALLOC, 16'd1, 11'd3);        // 0..2
    put_request(OP_ALLOC, 16'd2, 11'd5);        // 3..7
    put_request(OP_ALLOC, 16'd3, 11'd2);        // 8..9
    put_request(OP_ALLOC, 16'd4, 11'd10);       // 10..19
    put_request(OP_ALLOC, 16'd5, 11'd4);        // 20..23
    put_request(OP_CLEAR, 16'd2, '0);           // hole of 5 at 3
    put_request(OP_CLEAR, 16'd4, '0);           // hole of 10 at 10
    drain();
    set_policy(POL_BEST);
    put_request(OP_ALLOC, 16'h8000, 11'd4);     // smallest hole
    put_request(OP_ALLOC, 16'h8001, 11'd6);
    drain();
    set_policy(POL_WORST);
    put_request(OP_ALLOC, 16'h4000, 11'd4);     // tail run
    drain();
    set_policy(POL_SPARE);
    put_request(OP_ALLOC, 16'h2000, 11'd1);     // first free cell
    put_request(OP_ALLOC, 16'h1234, 11'd1000);  // no run that long
    put_request(OP_CLEAR, 16'd1, '0);
    drain();
    set_policy(POL_BEST);
    put_request(OP_ALLOC, 16'h0100, 11'd2);
    drain();

    // random phases; one long reply hold-off, last phase runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      set_policy(pol_order[ph]);
      if (ph == 2) hold_ask <= hold_ask + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      drain();
    end

    repeat (2200) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
